/* rtl/mlt_pkg.sv */
// shared types and constants for the mac learning table
`timescale 1ns / 1ps
package mlt_pkg;

    localparam int MAC_W = 48;
    localparam int PORT_W = 4;
    localparam int AGE_W = 12;
    localparam int CNT_W = 7;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int CHUNK_W = 8;

    typedef enum logic [1:0] {
        FUNC_LEARN  = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } t_cmd;

    typedef struct packed {
        logic              hit;
        logic [PORT_W-1:0] port;
        logic [CNT_W-1:0]  aged;
        logic              dropped;
    } t_result;

endpackage

/* rtl/mlt_front.sv */
// front end: accepts and classifies items into a two-deep command queue
`timescale 1ns / 1ps
module mlt_front
    import mlt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_func,
    input  logic [MAC_W-1:0]  i_mac_address,
    input  logic [PORT_W-1:0] i_port_in,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;

    always_comb begin
        cmd_in.func = t_func'(i_func);
        cmd_in.mac  = i_mac_address;
        cmd_in.port = i_port_in;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

/* rtl/mlt_back.sv */
// back end: associative table, aging and result register
`timescale 1ns / 1ps
module mlt_back
    import mlt_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic [AGE_W-1:0] i_age_timeout,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ready
);

    localparam int NCHUNK = (ENTRIES + CHUNK_W - 1) / CHUNK_W;
    localparam int PW = NCHUNK * CHUNK_W;
    localparam int LW = $clog2(NCHUNK + 1);
    localparam int AW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_COUNT = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state              r_state;
    logic [ENTRIES-1:0]  r_valid;
    logic [MAC_W-1:0]    r_mac  [ENTRIES];
    logic [PORT_W-1:0]   r_port [ENTRIES];
    logic [AGE_W-1:0]    r_age  [ENTRIES];
    logic [PW-1:0]       r_mask;
    logic [LW-1:0]       r_left;
    logic [AW-1:0]       r_acc;
    logic                r_res_valid;
    t_result             r_res;
    t_result             n_res;

    logic [ENTRIES-1:0]  match;
    logic [ENTRIES-1:0]  match_first;
    logic [ENTRIES-1:0]  free_first;
    logic [ENTRIES-1:0]  expire;
    logic [AGE_W-1:0]    age_next [ENTRIES];
    logic [PORT_W-1:0]   hit_port;
    logic                any_match;
    logic                any_free;
    logic                res_free;
    logic                take;
    logic [3:0]          chunk_cnt;

    assign res_free  = !r_res_valid || i_res_ready;
    assign take      = (r_state == S_IDLE) && i_cmd_valid && res_free;
    assign o_cmd_pop = take;

    always_comb begin
        hit_port = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_mac[i] == i_cmd.mac);
            age_next[i] = (r_age[i] != AGE_MAX) ? r_age[i] + 1'b1 : r_age[i];
            expire[i] = r_valid[i] && (age_next[i] > i_age_timeout);
        end
        // lowest set bit isolation; free_first isolates the lowest clear bit of r_valid
        match_first = match & (~match + 1'b1);
        free_first  = ~r_valid & (r_valid + 1'b1);
        any_match   = |match;
        any_free    = ~&r_valid;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_port = hit_port | (match_first[i] ? r_port[i] : '0);
        end
        chunk_cnt = '0;
        for (int b = 0; b < CHUNK_W; b++) begin
            chunk_cnt = chunk_cnt + {3'b0, r_mask[b]};
        end
    end

    // next result word
    always_comb begin
        n_res = '0;
        if (r_state == S_DONE) begin
            n_res.aged = (32'(r_acc) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(r_acc);
        end else begin
            case (i_cmd.func)
                FUNC_LEARN:  n_res.dropped = !any_match && !any_free;
                FUNC_LOOKUP: begin
                    n_res.hit  = any_match;
                    n_res.port = hit_port;
                end
                default: ;
            endcase
        end
    end

    // table payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (take && i_cmd.func == FUNC_LEARN) begin
                if (match_first[i] || (!any_match && free_first[i])) begin
                    r_port[i] <= i_cmd.port;
                    r_age[i]  <= '0;
                end
                if (!any_match && free_first[i]) begin
                    r_mac[i] <= i_cmd.mac;
                end
            end else if (take && i_cmd.func == FUNC_TICK && r_valid[i]) begin
                r_age[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cmd.func == FUNC_TICK) begin
            r_mask <= PW'(expire);
            r_left <= LW'(NCHUNK);
            r_acc  <= '0;
        end else if (r_state == S_COUNT) begin
            r_mask <= r_mask >> CHUNK_W;
            r_left <= r_left - 1'b1;
            r_acc  <= r_acc + AW'(chunk_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || (r_state == S_DONE && res_free)) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        unique case (i_cmd.func)
                            FUNC_LEARN: begin
                                if (!any_match) begin
                                    r_valid <= r_valid | free_first;
                                end
                            end
                            FUNC_LOOKUP: ;
                            FUNC_TICK: begin
                                r_valid <= r_valid & ~expire;
                                r_state <= S_COUNT;
                            end
                            FUNC_CLEAR: r_valid <= '0;
                            default: ;
                        endcase
                    end
                end
                S_COUNT: begin
                    if (r_left == LW'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if ((take && i_cmd.func != FUNC_TICK) || (r_state == S_DONE && res_free)) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* rtl/mac_learning_table_with_aging_unit.sv */
// top level of the mac learning table with aging
//
// channel   direction  handshake                 payload
// input     in         i_valid / o_ready         i_func, i_mac_address, i_port_in
// result    out        o_valid / i_ready         o_hit, o_port_out, o_aged_count, o_dropped
// config    in         i_cfg_valid / o_cfg_ready i_age_timeout
//
// learn, lookup and clear pass from transfer to result through the command
// queue and then the table, where all entries are compared in parallel
// a tick also runs a removal count that walks the expiry mask a byte per cycle
// reset is synchronous and active low; it empties the table and sets the timeout to 30
// the two-deep queue keeps taking items, until it holds two, while the table stalls on a full result register
`timescale 1ns / 1ps
module mac_learning_table_with_aging_unit
    import mlt_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_func,
    input  logic [MAC_W-1:0]  i_mac_address,
    input  logic [PORT_W-1:0] i_port_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_hit,
    output logic [PORT_W-1:0] o_port_out,
    output logic [CNT_W-1:0]  o_aged_count,
    output logic              o_dropped,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [AGE_W-1:0]  i_age_timeout
);

    // age timeout register, always writable
    logic [AGE_W-1:0] r_age_timeout;
    logic             cmd_valid;
    logic             cmd_pop;
    t_cmd             cmd;
    t_result          res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_timeout <= AGE_W'(30);
        end else if (i_cfg_valid) begin
            r_age_timeout <= i_age_timeout;
        end
    end

    // front end: classify and queue
    mlt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_mac_address (i_mac_address),
        .i_port_in     (i_port_in),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    // back end: table search, update and aging
    mlt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .i_age_timeout (r_age_timeout),
        .o_res_valid   (o_valid),
        .o_res         (res),
        .i_res_ready   (i_ready)
    );

    assign o_hit        = res.hit;
    assign o_port_out   = res.port;
    assign o_aged_count = res.aged;
    assign o_dropped    = res.dropped;

`ifndef SYNTHESIS
    // a result carries at most one kind of report
    a_res_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_aged_count == '0 && !o_dropped)
        else $error("lookup result carries tick or learn fields");

    a_miss_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_port_out == '0)
        else $error("port reported without a hit");

    // the queue only fills through a transfer
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(i_valid))
        else $error("input ready fell without a transfer");
`endif

endmodule
